// File: rtl/fcjt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcjt_pkg: shared types for the fan-out completion join table
// Status codes, the lookup token passed along the cell row and the
// allocation broadcast from the tail of the row.
// ----------------------------------------------------------------------------
package fcjt_pkg;

  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int BC_W     = 4;
  // wide enough for any branch count the row can be built for
  localparam int NEED_W   = 8;

  localparam logic [BC_W-1:0] BC_RESET = BC_W'(2);
  localparam logic [BC_W-1:0] BC_MIN   = BC_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING  = 2'd0,
    ST_RELEASED = 2'd1,
    ST_DROPPED  = 2'd2
  } status_e;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            done;
    status_e         status;
    logic            free_found;
  } token_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] id;
  } alloc_t;

endpackage

`default_nettype wire

// File: rtl/fcjt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcjt_in_if: confirmation channel
// Carries one item id per handshake.
// ----------------------------------------------------------------------------
interface fcjt_in_if;
  logic                      valid;
  logic                      ready;
  logic [fcjt_pkg::ID_W-1:0] item_id;

  modport source (output valid, output item_id, input ready);
  modport sink   (input valid, input item_id, output ready);
endinterface

`default_nettype wire

// File: rtl/fcjt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcjt_out_if: result channel
// Carries the echoed item id and its status code.
// ----------------------------------------------------------------------------
interface fcjt_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcjt_pkg::ID_W-1:0]     result_id;
  logic [fcjt_pkg::STATUS_W-1:0] status;

  modport source (output valid, output result_id, output status, input ready);
  modport sink   (input valid, input result_id, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/fcjt_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcjt_cfg_if: configuration write channel
// Carries the branch count register write data.
// ----------------------------------------------------------------------------
interface fcjt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fcjt_pkg::BC_W-1:0] branch_count;

  modport source (output valid, output branch_count, input ready);
  modport sink   (input valid, input branch_count, output ready);
endinterface

`default_nettype wire

// File: rtl/fcjt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcjt_cell: one table entry of the join row
// Holds one pending id with its hit count, checks the passing lookup token
// against it and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module fcjt_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int HIT_W = 3
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire [fcjt_pkg::NEED_W-1:0]   need_i,
  input  wire fcjt_pkg::token_t        tok_i,
  input  wire [IDX_W-1:0]              free_idx_i,
  input  wire fcjt_pkg::alloc_t        alloc_i,
  input  wire [IDX_W-1:0]              alloc_idx_i,
  output fcjt_pkg::token_t             tok_o,
  output logic [IDX_W-1:0]             free_idx_o
);

  logic                      valid_q, valid_d;
  logic [fcjt_pkg::ID_W-1:0] item_q, item_d;
  logic [HIT_W-1:0]          hits_q, hits_d;
  fcjt_pkg::token_t          tok_q, tok_d;
  logic [IDX_W-1:0]          free_idx_q, free_idx_d;
  logic                      match;

  always_comb begin
    tok_d      = tok_i;
    free_idx_d = free_idx_i;
    valid_d    = valid_q;
    item_d     = item_q;
    hits_d     = hits_q;
    match      = tok_i.valid && !tok_i.done && valid_q && (item_q == tok_i.id);
    if (adv_i) begin
      if (match) begin
        tok_d.done = 1'b1;
        if ((fcjt_pkg::NEED_W'(hits_q) + fcjt_pkg::NEED_W'(1)) >= need_i) begin
          valid_d      = 1'b0;
          tok_d.status = fcjt_pkg::ST_RELEASED;
        end else begin
          hits_d       = hits_q + HIT_W'(1);
          tok_d.status = fcjt_pkg::ST_PENDING;
        end
      end else if (tok_i.valid && !valid_q && !tok_i.free_found) begin
        // lowest free entry seen so far
        tok_d.free_found = 1'b1;
        free_idx_d       = IDX_W'(INDEX);
      end
    end
    // new entry written from the tail once the token has seen every cell
    if (alloc_i.en && (alloc_idx_i == IDX_W'(INDEX))) begin
      valid_d = 1'b1;
      item_d  = alloc_i.id;
      hits_d  = HIT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hits_q <= hits_d;
    if (adv_i) begin
      free_idx_q <= free_idx_d;
    end
  end

  assign tok_o      = tok_q;
  assign free_idx_o = free_idx_q;

endmodule

`default_nettype wire

// File: rtl/fanout_completion_join_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fanout_completion_join_table: joins done reports from fan-out branches
// Counts confirmations per item id in a row of table cells and releases an
// id once every branch has reported it; new ids that find no room are dropped.
// ----------------------------------------------------------------------------
// Each accepted item id walks the row of TABLE_DEPTH cells one cell per
// cycle, held at the tail while the output is full and stalled. A cell
// holding the id counts the hit, or frees itself and marks the item
// released when its count plus one reaches the branch count (branch_count
// clamped to 2..MAX_BRANCHES). If no cell holds the id, the lowest free
// cell seen on the walk is written at the end of the row; with no free
// cell the item is reported as dropped. One item is in the row at a time:
// a new item is taken only once the last has walked the cell row and been
// handed into the output register. Result status: 0 pending, 1 released,
// 2 dropped. A branch count write is held off while an item walks the row,
// and an offered write takes precedence over a new item.
module fanout_completion_join_table #(
  parameter int TABLE_DEPTH  = 16,
  parameter int MAX_BRANCHES = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  fcjt_in_if.sink           in_i,
  fcjt_out_if.source        out_o,
  fcjt_cfg_if.sink          cfg_i
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HIT_W = $clog2(MAX_BRANCHES);

  logic [fcjt_pkg::BC_W-1:0]   branch_count_q;
  logic [fcjt_pkg::NEED_W-1:0] need;
  logic                        busy_q, busy_d;
  logic                        out_valid_q, out_valid_d;
  logic [fcjt_pkg::ID_W-1:0]   out_id_q;
  fcjt_pkg::status_e           out_status_q, result_status;
  logic                        in_accept, consume, adv;
  fcjt_pkg::alloc_t            alloc;
  fcjt_pkg::token_t            tok_head;
  logic [TABLE_DEPTH:0]        tok_valid_vec;

  fcjt_pkg::token_t            tok      [TABLE_DEPTH+1];
  logic [IDX_W-1:0]            free_idx [TABLE_DEPTH+1];

  // branch count register, written only with no item in the row
  assign cfg_i.ready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_count_q <= fcjt_pkg::BC_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      branch_count_q <= cfg_i.branch_count;
    end
  end

  always_comb begin
    if (branch_count_q < fcjt_pkg::BC_MIN) begin
      need = fcjt_pkg::NEED_W'(fcjt_pkg::BC_MIN);
    end else if (fcjt_pkg::NEED_W'(branch_count_q) > fcjt_pkg::NEED_W'(MAX_BRANCHES)) begin
      need = fcjt_pkg::NEED_W'(MAX_BRANCHES);
    end else begin
      need = fcjt_pkg::NEED_W'(branch_count_q);
    end
  end

  // input side
  assign in_i.ready = !busy_q && !cfg_i.valid;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    tok_head        = '0;
    tok_head.valid  = in_accept;
    tok_head.id     = in_i.item_id;
    tok_head.status = fcjt_pkg::ST_DROPPED;
  end

  assign tok[0]      = tok_head;
  assign free_idx[0] = '0;

  // the row only holds when the token sits at the tail behind a full output
  assign consume = tok[TABLE_DEPTH].valid && (!out_valid_q || out_o.ready);
  assign adv     = !tok[TABLE_DEPTH].valid || !out_valid_q || out_o.ready;

  always_comb begin
    alloc.en = consume && !tok[TABLE_DEPTH].done && tok[TABLE_DEPTH].free_found;
    alloc.id = tok[TABLE_DEPTH].id;
    if (tok[TABLE_DEPTH].done) begin
      result_status = tok[TABLE_DEPTH].status;
    end else if (tok[TABLE_DEPTH].free_found) begin
      result_status = fcjt_pkg::ST_PENDING;
    end else begin
      result_status = fcjt_pkg::ST_DROPPED;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fcjt_cell #(
      .INDEX (g),
      .IDX_W (IDX_W),
      .HIT_W (HIT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .need_i      (need),
      .tok_i       (tok[g]),
      .free_idx_i  (free_idx[g]),
      .alloc_i     (alloc),
      .alloc_idx_i (free_idx[TABLE_DEPTH]),
      .tok_o       (tok[g+1]),
      .free_idx_o  (free_idx[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_vld
    assign tok_valid_vec[g] = tok[g].valid;
  end

  // control and output register
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (consume) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
    end
    if (in_accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      out_id_q     <= tok[TABLE_DEPTH].id;
      out_status_q <= result_status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.result_id = out_id_q;
  assign out_o.status    = fcjt_pkg::STATUS_W'(out_status_q);

  // at most one item walks the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid_vec[TABLE_DEPTH:1]) <= 1)
    else $error("more than one item in the cell row");

  // an item in the row always means the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid_vec[TABLE_DEPTH:1] != '0) |-> busy_q)
    else $error("item in the row while idle");

  // a new item is only taken after the previous one left the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> ($countones(tok_valid_vec[TABLE_DEPTH:1]) == 1) && tok[1].valid)
    else $error("accepted item did not enter the row alone");

  // an allocation (walk found neither a hit nor a full table) shows as a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc.en |=> out_o.valid && (out_o.status == fcjt_pkg::STATUS_W'(fcjt_pkg::ST_PENDING)))
    else $error("allocation without a pending result");

endmodule

`default_nettype wire

// File: sim/fcjt_join_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcjt_join_checker: result checker for the fan-out completion join table
// Watches the confirmation, result and configuration channels, keeps its own
// copy of the pending-id table, predicts the status of every accepted item
// and compares each result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module fcjt_join_checker #(
  parameter int TABLE_DEPTH  = 16,
  parameter int MAX_BRANCHES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [fcjt_pkg::ID_W-1:0]     in_item_id_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [fcjt_pkg::ID_W-1:0]     out_result_id_i,
  input  logic [fcjt_pkg::STATUS_W-1:0] out_status_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fcjt_pkg::BC_W-1:0]     cfg_branch_count_i,
  output int                            waiting_o,
  output int                            fail_count_o
);

  typedef struct packed {
    logic [fcjt_pkg::ID_W-1:0] id;
    fcjt_pkg::status_e         status;
  } join_result_t;

  logic                      slot_used [TABLE_DEPTH];
  logic [fcjt_pkg::ID_W-1:0] slot_id   [TABLE_DEPTH];
  logic [2:0]                slot_hits [TABLE_DEPTH];
  logic [fcjt_pkg::BC_W-1:0] branch_cnt;

  join_result_t expected_joins [$];
  join_result_t head;
  int           fails;

  initial begin
    fails        = 0;
    waiting_o    = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  // one confirmation against the table, returns the status it earns
  function automatic fcjt_pkg::status_e join_confirm(input logic [fcjt_pkg::ID_W-1:0] id);
    int hit_slot;
    int free_slot;
    int need;
    hit_slot  = -1;
    free_slot = -1;
    need      = int'(branch_cnt);
    if (need < int'(fcjt_pkg::BC_MIN)) need = int'(fcjt_pkg::BC_MIN);
    if (need > MAX_BRANCHES) need = MAX_BRANCHES;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (slot_used[k]) begin
        if (hit_slot < 0 && slot_id[k] == id) hit_slot = k;
      end else if (free_slot < 0) begin
        free_slot = k;
      end
    end
    if (hit_slot >= 0) begin
      // >= so a lowered branch count frees the entry on its next hit
      if (int'(slot_hits[hit_slot]) + 1 >= need) begin
        slot_used[hit_slot] = 1'b0;
        return fcjt_pkg::ST_RELEASED;
      end
      slot_hits[hit_slot] = slot_hits[hit_slot] + 3'd1;
      return fcjt_pkg::ST_PENDING;
    end
    if (free_slot >= 0) begin
      slot_used[free_slot] = 1'b1;
      slot_id[free_slot]   = id;
      slot_hits[free_slot] = 3'd1;
      return fcjt_pkg::ST_PENDING;
    end
    return fcjt_pkg::ST_DROPPED;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_cnt = fcjt_pkg::BC_RESET;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        slot_used[k] = 1'b0;
        slot_id[k]   = '0;
        slot_hits[k] = '0;
      end
      expected_joins.delete();
      waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) branch_cnt = cfg_branch_count_i;

      // results first: an item accepted at this edge cannot have left yet
      if (out_valid_i && out_ready_i) begin
        if (expected_joins.size() == 0) begin
          report_mismatch($sformatf("result id=%h status=%0d with no item waiting",
                                    out_result_id_i, out_status_i));
        end else begin
          head = expected_joins.pop_front();
          if (out_result_id_i !== head.id)
            report_mismatch($sformatf("result_id %h, expected %h",
                                      out_result_id_i, head.id));
          if (out_status_i !== head.status)
            report_mismatch($sformatf("status %0d for id %h, expected %0d (%s)",
                                      out_status_i, head.id, head.status,
                                      head.status.name()));
        end
      end

      if (in_valid_i && in_ready_i) begin
        head.id        = in_item_id_i;
        head.status    = join_confirm(in_item_id_i);
        expected_joins = {expected_joins, head};
      end

      waiting_o <= expected_joins.size();
    end
    fail_count_o <= fails;
  end

endmodule

// File: sim/tb_fanout_completion_join_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fanout_completion_join_table: testbench for the completion join table
// Drives confirmations made of complete, partial and noise id sequences under
// a range of branch counts, with random idling on both channels and a long
// output hold-off; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_fanout_completion_join_table;

  localparam int TABLE_DEPTH  = 16;
  localparam int MAX_BRANCHES = 8;
  localparam int HOLD_LEN     = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fcjt_in_if  confirm_if ();
  fcjt_out_if result_if ();
  fcjt_cfg_if cfg_if ();

  int waiting;
  int fail_count;
  int cycle_cnt = 0;

  // stimulus mode, changed with nonblocking writes so the receiver sees it cleanly
  logic idle_en  = 1'b1;
  logic hold_arm = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // ids the table should be holding and their hit counts, used to steer stimulus
  logic [fcjt_pkg::ID_W-1:0] open_id [$];
  int                        open_hits [$];
  int                        need_now;

  fanout_completion_join_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_BRANCHES (MAX_BRANCHES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (confirm_if),
    .out_o  (result_if),
    .cfg_i  (cfg_if)
  );

  fcjt_join_checker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_BRANCHES (MAX_BRANCHES)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (confirm_if.valid),
    .in_ready_i         (confirm_if.ready),
    .in_item_id_i       (confirm_if.item_id),
    .out_valid_i        (result_if.valid),
    .out_ready_i        (result_if.ready),
    .out_result_id_i    (result_if.result_id),
    .out_status_i       (result_if.status),
    .cfg_valid_i        (cfg_if.valid),
    .cfg_ready_i        (cfg_if.ready),
    .cfg_branch_count_i (cfg_if.branch_count),
    .waiting_o          (waiting),
    .fail_count_o       (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("fanout_completion_join_table test failed");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off whenever one is armed
  always @(posedge clk) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= HOLD_LEN;
      result_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(99) < 25) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  function automatic int clamp_need(input logic [fcjt_pkg::BC_W-1:0] bc);
    int n;
    n = int'(bc);
    if (n < int'(fcjt_pkg::BC_MIN)) n = int'(fcjt_pkg::BC_MIN);
    if (n > MAX_BRANCHES) n = MAX_BRANCHES;
    return n;
  endfunction

  function automatic void note_sent(input logic [fcjt_pkg::ID_W-1:0] id);
    for (int k = 0; k < open_id.size(); k++) begin
      if (open_id[k] == id) begin
        if (open_hits[k] + 1 >= need_now) begin
          open_id.delete(k);
          open_hits.delete(k);
        end else begin
          open_hits[k]++;
        end
        return;
      end
    end
    if (open_id.size() < TABLE_DEPTH) begin
      open_id   = {open_id, id};
      open_hits = {open_hits, 1};
    end
  endfunction

  // mostly further confirmations of pending ids, the rest fresh or edge ids
  function automatic logic [fcjt_pkg::ID_W-1:0] pick_id(input int fresh_pct);
    if (open_id.size() == 0 || $urandom_range(99) < fresh_pct) begin
      case ($urandom_range(9))
        0:       return '0;
        1:       return '1;
        default: return $urandom();
      endcase
    end
    return open_id[$urandom_range(open_id.size() - 1)];
  endfunction

  task automatic send_confirm(input logic [fcjt_pkg::ID_W-1:0] id);
    if (idle_en && $urandom_range(99) < 25) begin
      confirm_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    confirm_if.valid   <= 1'b1;
    confirm_if.item_id <= id;
    @(posedge clk);
    while (!confirm_if.ready) @(posedge clk);
    note_sent(id);
  endtask

  task automatic wait_drained();
    confirm_if.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    // the walk of the last item may still be settling
    repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_branch_count(input logic [fcjt_pkg::BC_W-1:0] val);
    cfg_if.valid        <= 1'b1;
    cfg_if.branch_count <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    need_now = clamp_need(val);
  endtask

  task automatic drain_table();
    while (open_id.size() != 0) send_confirm(open_id[0]);
  endtask

  task automatic run_phase(input logic [fcjt_pkg::BC_W-1:0] bc, input int n_items,
                           input int fresh_pct, input logic idle, input logic hold,
                           input logic drain);
    wait_drained();
    idle_en <= idle;
    write_branch_count(bc);
    if (hold) hold_arm <= ~hold_arm;
    repeat (n_items) send_confirm(pick_id(fresh_pct));
    if (drain) drain_table();
  endtask

  initial begin
    confirm_if.valid    <= 1'b0;
    confirm_if.item_id  <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.branch_count <= fcjt_pkg::BC_RESET;
    need_now = clamp_need(fcjt_pkg::BC_RESET);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset branch count: pairs release, then fill every entry
    send_confirm('0);
    send_confirm('0);
    send_confirm('1);
    send_confirm('1);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      case (k)
        0:       send_confirm(32'hAAAA_AAAA);
        1:       send_confirm(32'h5555_5555);
        default: send_confirm(32'h1000_0000 + k);
      endcase
    end
    // new id into a full table is dropped, a held id still hits
    send_confirm(32'h1234_5678);
    send_confirm(32'h5555_5555);

    run_phase(4'd8,  140, 30, 1'b1, 1'b0, 1'b0);
    // lowered while entries hold several hits
    run_phase(4'd3,  140, 40, 1'b1, 1'b1, 1'b0);
    run_phase(4'd0,  130, 35, 1'b0, 1'b0, 1'b0);
    run_phase(4'd15, 130, 20, 1'b1, 1'b0, 1'b1);
    run_phase(4'd1,  120, 45, 1'b1, 1'b0, 1'b0);
    run_phase(4'd9,  130, 25, 1'b1, 1'b1, 1'b0);
    run_phase(4'd5,  120, 30, 1'b1, 1'b0, 1'b1);
    run_phase(4'd2,  110, 40, 1'b1, 1'b0, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("fanout_completion_join_table test passed");
    end else begin
      $display("fanout_completion_join_table test failed");
    end
    $finish;
  end

endmodule
